// ===== src/tmtcg_pkg.sv =====
`timescale 1ns / 1ps

package tmtcg_pkg;

    localparam int DEFAULT_MAX_SOURCE = 256;
    localparam int DEFAULT_MAX_REPAIR = 256;
    localparam int INDEX_LIMIT        = 256;

    localparam logic [31:0] MAT1      = 32'h8f7011ee;
    localparam logic [31:0] MAT2      = 32'hfc78ff1f;
    localparam logic [31:0] TMAT      = 32'h3793fdff;
    localparam logic [31:0] MIX_MULT  = 32'd1812433253;
    localparam logic [30:0] LOW31     = 31'h7fffffff;

    localparam logic [31:0] CERT_W0   = 32'h00000054;
    localparam logic [31:0] CERT_W1   = 32'h00000049;
    localparam logic [31:0] CERT_W2   = 32'h0000004e;
    localparam logic [31:0] CERT_W3   = 32'h00000059;

    localparam logic [3:0]  MIX_FIRST = 4'd1;
    localparam logic [3:0]  MIX_LAST  = 4'd7;
    localparam logic [3:0]  PRE_STEPS = 4'd8;

    localparam int          ADDR_W    = 4;
    localparam logic [1:0]  REG_SEED       = 2'd0;
    localparam logic [1:0]  REG_NUM_SOURCE = 2'd1;
    localparam logic [1:0]  REG_NUM_REPAIR = 2'd2;

    typedef logic [3:0][31:0] words_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_MUL,
        ST_MIX_XOR,
        ST_CERT,
        ST_ADVANCE,
        ST_TEMPER
    } eng_state_t;

    typedef struct packed {
        logic start;
        logic reseed;
        logic take;
    } eng_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;

endpackage

// ===== src/tinymt_coefficient_generator_unit.sv =====
`timescale 1ns / 1ps

// Coefficient matrix generator on a TinyMT32 core.
// Input channel s_*: one transfer per coefficient; s_restart = 1 reseeds the
// generator from the seed register and returns to row 0, column 0 first.
// Result channel m_*: one transfer per input transfer, in order, carrying the
// low byte of the tempered output, its row and column, and a last flag on the
// final entry of the matrix.
// Configuration over APB: seed at 0x0, num_source at 0x4, num_repair at 0x8.
// A plain draw runs one state update and then the tempering step, which holds
// until the output register is free; a restart first runs seven mixing rounds
// through the single shared multiplier (a multiply state and a xor state each),
// one certification step and nine state updates through the single update unit.
// One item is in flight at a time; s_ready drops while the core works.
// A finished result sits in the output register; the next item may be taken
// meanwhile, and the core holds its result until that register is free.
// Reset clears the generator words (draws before any restart use all zero),
// the position counters and the registers (seed 0, both sizes 1).
module tinymt_coefficient_generator_unit #(
    parameter int MAX_SOURCE = tmtcg_pkg::DEFAULT_MAX_SOURCE,
    parameter int MAX_REPAIR = tmtcg_pkg::DEFAULT_MAX_REPAIR
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_coefficient,
    output logic [7:0]                  m_row,
    output logic [7:0]                  m_column,
    output logic                        m_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmtcg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tmtcg_pkg::*;

    localparam int ROW_LIM_I = (MAX_SOURCE < INDEX_LIMIT) ? MAX_SOURCE : INDEX_LIMIT;
    localparam int COL_LIM_I = (MAX_REPAIR < INDEX_LIMIT) ? MAX_REPAIR : INDEX_LIMIT;
    localparam logic [8:0] ROW_LIM = (ROW_LIM_I < 1) ? 9'd1 : 9'(ROW_LIM_I);
    localparam logic [8:0] COL_LIM = (COL_LIM_I < 1) ? 9'd1 : 9'(COL_LIM_I);

    logic [31:0] seed_reg;
    logic [8:0]  num_source_reg;
    logic [8:0]  num_repair_reg;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic        m_valid_reg;
    logic [7:0]  coef_reg;
    logic [7:0]  out_row_reg;
    logic [7:0]  out_col_reg;
    logic        last_reg;

    eng_cmd_t    cmd;
    eng_status_t status;
    logic [7:0]  eng_coef;
    logic        cfg_write;
    logic        in_xfer;
    logic [8:0]  rows_clip, cols_clip;
    logic [8:0]  rows_eff, cols_eff;
    logic [7:0]  last_row, last_col;
    logic        row_end, col_end;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign s_ready   = !status.busy;
    assign in_xfer   = s_valid && s_ready;

    assign cmd = '{start: in_xfer, reseed: s_restart, take: (!m_valid_reg || m_ready)};

    tmtcg_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .seed        (seed_reg),
        .status      (status),
        .coefficient (eng_coef)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg       <= '0;
            num_source_reg <= 9'd1;
            num_repair_reg <= 9'd1;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_SEED:       seed_reg       <= pwdata;
                REG_NUM_SOURCE: num_source_reg <= pwdata[8:0];
                REG_NUM_REPAIR: num_repair_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SEED:       prdata = seed_reg;
            REG_NUM_SOURCE: prdata = {23'd0, num_source_reg};
            REG_NUM_REPAIR: prdata = {23'd0, num_repair_reg};
            default:        prdata = '0;
        endcase
    end

    assign rows_clip = (num_source_reg == 9'd0) ? 9'd1 : num_source_reg;
    assign cols_clip = (num_repair_reg == 9'd0) ? 9'd1 : num_repair_reg;
    assign rows_eff  = (rows_clip > ROW_LIM) ? ROW_LIM : rows_clip;
    assign cols_eff  = (cols_clip > COL_LIM) ? COL_LIM : cols_clip;
    assign last_row  = 8'(rows_eff - 9'd1);
    assign last_col  = 8'(cols_eff - 9'd1);
    assign row_end   = (row_reg >= last_row);
    assign col_end   = (col_reg >= last_col);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (in_xfer && s_restart) begin
            row_next = '0;
            col_next = '0;
        end else if (status.done) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? 8'd0 : row_reg + 8'd1;
            end else begin
                col_next = col_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (status.done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (status.done) begin
            coef_reg    <= eng_coef;
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            last_reg    <= row_end && col_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_coefficient = coef_reg;
    assign m_row         = out_row_reg;
    assign m_column      = out_col_reg;
    assign m_last        = last_reg;

`ifndef ASSERT_OFF
    a_done_room: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |-> (!m_valid_reg || m_ready))
        else $error("result finished while output register still full");

    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |=> m_valid_reg)
        else $error("finished result not presented");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("input still ready after a transfer");
`endif

endmodule

// ===== src/tmtcg_engine.sv =====
`timescale 1ns / 1ps

module tmtcg_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tmtcg_pkg::eng_cmd_t   cmd,
    input  logic [31:0]           seed,
    output tmtcg_pkg::eng_status_t status,
    output logic [7:0]            coefficient
);
    import tmtcg_pkg::*;

    eng_state_t  state_reg, state_next;
    words_t      words_reg, words_next;
    logic [31:0] prod_reg, prod_next;
    logic [3:0]  cnt_reg, cnt_next;

    logic [31:0] mix_in;
    logic [31:0] mix_word;
    words_t      rot_words;
    words_t      adv_words;
    logic [31:0] temper_t1;
    logic [31:0] temper_t0;

    function automatic words_t advance(input words_t w);
        logic [31:0] x;
        logic [31:0] y;
        words_t      r;
        x = {1'b0, w[0][30:0]} ^ w[1] ^ w[2];
        x = x ^ (x << 1);
        y = w[3] ^ (w[3] >> 1) ^ x;
        r[0] = w[1];
        r[1] = w[2];
        r[2] = x ^ (y << 10);
        r[3] = y;
        if (y[0]) begin
            r[1] = r[1] ^ MAT1;
            r[2] = r[2] ^ MAT2;
        end
        return r;
    endfunction

    assign mix_in    = words_reg[0] ^ (words_reg[0] >> 30);
    assign mix_word  = words_reg[1] ^ ({28'd0, cnt_reg} + prod_reg);
    assign rot_words = {words_reg[0], words_reg[3], words_reg[2], words_reg[1]};
    assign adv_words = advance(words_reg);
    assign temper_t1 = words_reg[0] + (words_reg[2] >> 8);
    assign temper_t0 = words_reg[3] ^ temper_t1 ^ (temper_t1[0] ? TMAT : 32'd0);
    assign coefficient = temper_t0[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            words_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            words_reg <= words_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    always_comb begin
        state_next  = state_reg;
        words_next  = words_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        status.busy = (state_reg != ST_IDLE);
        status.done = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    if (cmd.reseed) begin
                        words_next = {TMAT, MAT2, MAT1, seed};
                        cnt_next   = MIX_FIRST;
                        state_next = ST_MIX_MUL;
                    end else begin
                        cnt_next   = '0;
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_MIX_MUL: begin
                prod_next  = 32'(mix_in * MIX_MULT);
                state_next = ST_MIX_XOR;
            end
            ST_MIX_XOR: begin
                // rotate so the word just written becomes the next multiplier input
                words_next = {words_reg[0], words_reg[3], words_reg[2], mix_word};
                if (cnt_reg == MIX_LAST) begin
                    state_next = ST_CERT;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = ST_MIX_MUL;
                end
            end
            ST_CERT: begin
                if (rot_words[0][30:0] == 31'd0 && rot_words[1] == 32'd0 &&
                    rot_words[2] == 32'd0 && rot_words[3] == 32'd0) begin
                    words_next = {CERT_W3, CERT_W2, CERT_W1, CERT_W0};
                end else begin
                    words_next = rot_words;
                end
                cnt_next   = PRE_STEPS;
                state_next = ST_ADVANCE;
            end
            ST_ADVANCE: begin
                words_next = adv_words;
                if (cnt_reg == 4'd0) begin
                    state_next = ST_TEMPER;
                end else begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_TEMPER: begin
                if (cmd.take) begin
                    status.done = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
